// ===== src/nhm_pkg.sv =====
`default_nettype none

package nhm_pkg;

  // Default table depth
  localparam int unsigned SLOT_COUNT_DEF = 64;

  // Field widths
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned LOAD_W     = 16;
  localparam int unsigned ID_W       = 6;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned SUM_W      = 22;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_ADDR_W = 4;

  // Saturation limits
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX   = '1;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] SWEEP_INTERVAL_RST    = CFG_W'(10);
  localparam logic [CFG_W-1:0] HEARTBEAT_TIMEOUT_RST = CFG_W'(60);

  typedef enum logic [1:0] {
    REQ_HEARTBEAT = 2'd0,
    REQ_TICK      = 2'd1,
    REQ_QUERY     = 2'd2
  } nhm_req_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SWEEP_INTERVAL    = CFG_ADDR_W'(0),
    CFG_HEARTBEAT_TIMEOUT = CFG_ADDR_W'(1)
  } nhm_cfg_addr_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } nhm_state_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ID_W-1:0]   slot_id;
    logic [LOAD_W-1:0] load_count;
    logic              recovered;
  } nhm_req_t;

  typedef struct packed {
    logic              slot_active;
    logic [LOAD_W-1:0] slot_load;
    logic              flush_request;
    logic [ID_W-1:0]   flush_slot;
    logic [ID_W-1:0]   least_loaded_slot;
    logic [CNT_W-1:0]  active_slots;
    logic [SUM_W-1:0]  total_load;
    logic              swept;
  } nhm_rsp_t;

  typedef struct packed {
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_W-1:0]      wdata;
  } nhm_cfg_t;

  // One slot table entry
  typedef struct packed {
    logic              alive;
    logic [TIME_W-1:0] last_seen;
    logic [LOAD_W-1:0] load;
  } nhm_entry_t;

  // Per-cycle control from the sequencer to the scan datapath
  typedef struct packed {
    logic              first;      // scan start, reset search; counters too when sweeping
    logic              sweep;      // current item sweeps
    logic              proc;       // read data valid for this entry
    logic              hb_hit;     // heartbeat addresses this entry
    logic              q_hit;      // query addresses this entry
    logic              sweep_slot; // entry takes part in the sweep
    logic              recovered;
    logic [LOAD_W-1:0] load_count;
    logic [TIME_W-1:0] seconds;
    logic [CFG_W-1:0]  timeout;
  } nhm_scan_ctl_t;

  // Running results of the scan
  typedef struct packed {
    logic [CNT_W-1:0]  alive_count;
    logic [SUM_W-1:0]  load_sum;
    logic              q_active;
    logic [LOAD_W-1:0] q_load;
  } nhm_scan_sts_t;

endpackage

`default_nettype wire

// ===== src/nhm_stream_if.sv =====
`default_nettype none

// Valid/ready channel with a typed payload
interface nhm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/nhm_slot_ram.sv =====
`default_nettype none

module nhm_slot_ram
  import nhm_pkg::*;
#(
  parameter int unsigned DEPTH = SLOT_COUNT_DEF,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  wire              clk_i,
  input  wire              we_i,
  input  wire  [IDX_W-1:0] waddr_i,
  input  nhm_entry_t       wdata_i,
  input  wire  [IDX_W-1:0] raddr_i,
  output nhm_entry_t       rdata_o
);

  nhm_entry_t mem [DEPTH];
  nhm_entry_t rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/nhm_scan.sv =====
`default_nettype none

module nhm_scan
  import nhm_pkg::*;
#(
  parameter int unsigned IDX_W = $clog2(SLOT_COUNT_DEF)
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  nhm_scan_ctl_t    ctl_i,
  input  wire  [IDX_W-1:0] idx_i,
  input  nhm_entry_t       rdata_i,
  output nhm_entry_t       wdata_o,
  output logic [IDX_W-1:0] best_o,
  output nhm_scan_sts_t    sts_o
);

  logic [CNT_W-1:0]  count_q;
  logic [SUM_W-1:0]  sum_q;
  logic [IDX_W-1:0]  best_q;
  logic [LOAD_W-1:0] best_load_q;
  logic              found_q;
  logic              q_active_q;
  logic [LOAD_W-1:0] q_load_q;

  nhm_entry_t        ent;
  logic              cnt_inc;
  logic [LOAD_W-1:0] sum_add;
  logic [TIME_W-1:0] age;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_d;
  logic              better;

  // Entry update: heartbeat stamp or sweep retirement
  always_comb begin
    ent     = rdata_i;
    cnt_inc = 1'b0;
    sum_add = '0;
    age     = ctl_i.seconds - rdata_i.last_seen;
    if (ctl_i.hb_hit) begin
      ent.alive     = 1'b1;
      ent.last_seen = ctl_i.seconds;
      ent.load      = ctl_i.recovered ? '0 : ctl_i.load_count;
      cnt_inc       = !rdata_i.alive;
    end else if (ctl_i.sweep_slot && rdata_i.alive) begin
      if (age > TIME_W'(ctl_i.timeout)) begin
        ent.alive = 1'b0;
        ent.load  = '0;
      end else begin
        cnt_inc = 1'b1;
      end
      sum_add = ent.load;
    end
  end

  // Saturating load sum, carry means overflow
  assign sum_ext = {1'b0, sum_q} + (SUM_W+1)'(sum_add);
  assign sum_d   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];

  // Least loaded, later index wins a tie
  assign better = ent.alive && (!found_q || (ent.load <= best_load_q));

  // Persistent counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
    end else if (ctl_i.first) begin
      if (ctl_i.sweep) begin
        count_q <= '0;
        sum_q   <= '0;
      end
    end else if (ctl_i.proc) begin
      if (cnt_inc && (count_q != COUNT_MAX)) begin
        count_q <= count_q + CNT_W'(1);
      end
      sum_q <= sum_d;
    end
  end

  // Per-item search and query capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.first) begin
      best_q      <= '0;
      best_load_q <= '0;
      found_q     <= 1'b0;
      q_active_q  <= 1'b0;
      q_load_q    <= '0;
    end else if (ctl_i.proc) begin
      if (better) begin
        best_q      <= idx_i;
        best_load_q <= ent.load;
        found_q     <= 1'b1;
      end
      if (ctl_i.q_hit) begin
        q_active_q <= rdata_i.alive;
        q_load_q   <= rdata_i.load;
      end
    end
  end

  assign wdata_o           = ent;
  assign best_o            = best_q;
  assign sts_o.alive_count = count_q;
  assign sts_o.load_sum    = sum_q;
  assign sts_o.q_active    = q_active_q;
  assign sts_o.q_load      = q_load_q;

endmodule

`default_nettype wire

// ===== src/node_heartbeat_monitor.sv =====
`default_nettype none

// Channel  Dir  Payload                                      Request completes
// req_i    in   req_type, slot_id, load_count, recovered     valid && ready
// rsp_o    out  slot/flush/least-loaded/count/sum/swept       valid && ready
// cfg_i    in   addr (0 sweep_interval, 1 heartbeat_timeout)  valid && ready
//
// Each request makes one pass over the slot table, one entry per cycle
// through the single read and write port of the slot RAM.
// After reset a clearing pass zeroes the table; no request is taken
// meanwhile, configuration writes are.
// A new request is taken while the previous response waits in the output
// register; its pass stalls at the end until that register is free.
module node_heartbeat_monitor
  import nhm_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  nhm_stream_if.sink   req_i,
  nhm_stream_if.source rsp_o,
  nhm_stream_if.sink   cfg_i
);

  localparam int unsigned IDX_W  = $clog2(SLOT_COUNT);
  localparam int unsigned SCAN_W = $clog2(SLOT_COUNT + 1);
  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(SLOT_COUNT);
  localparam logic [IDX_W-1:0]  CLR_LAST  = IDX_W'(SLOT_COUNT - 1);

  nhm_state_e state_q, state_d;

  logic [CFG_W-1:0]  sweep_interval_q;
  logic [CFG_W-1:0]  heartbeat_timeout_q;
  logic [TIME_W-1:0] seconds_q;
  logic [TIME_W-1:0] last_sweep_q;
  nhm_req_t          item_q;
  logic              sweep_q;
  logic [SCAN_W-1:0] scan_cnt_q;
  logic [IDX_W-1:0]  clr_q;
  logic              rsp_valid_q;
  nhm_rsp_t          rsp_q;

  nhm_req_t          item;
  logic              req_acc;
  logic              rsp_load;
  logic [TIME_W-1:0] sec_inc;
  logic              sweep_now;
  logic              id_ok;
  logic [IDX_W-1:0]  slot_idx;
  logic [SCAN_W-1:0] cnt_m1;
  logic [IDX_W-1:0]  proc_idx;
  logic              scan_proc;
  logic              flush;

  nhm_scan_ctl_t     ctl;
  nhm_scan_sts_t     sts;
  logic [IDX_W-1:0]  best;
  nhm_entry_t        scan_wdata;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  nhm_entry_t        mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  nhm_entry_t        mem_rdata;

  assign item    = req_i.data;
  assign req_acc = req_i.valid && req_i.ready;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_interval_q    <= SWEEP_INTERVAL_RST;
      heartbeat_timeout_q <= HEARTBEAT_TIMEOUT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.addr)
        CFG_SWEEP_INTERVAL:    sweep_interval_q    <= cfg_i.data.wdata;
        CFG_HEARTBEAT_TIMEOUT: heartbeat_timeout_q <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  // Clock and sweep decision at accept
  assign sec_inc   = seconds_q + TIME_W'(1);
  assign sweep_now = (item.req_type == REQ_TICK) &&
                     ((sec_inc - last_sweep_q) >= TIME_W'(sweep_interval_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seconds_q    <= '0;
      last_sweep_q <= '0;
    end else if (req_acc && (item.req_type == REQ_TICK)) begin
      seconds_q <= sec_inc;
      if (sweep_now) begin
        last_sweep_q <= sec_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      item_q  <= item;
      sweep_q <= sweep_now;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      scan_cnt_q <= '0;
      clr_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      if (state_q == ST_SCAN) begin
        scan_cnt_q <= scan_cnt_q + SCAN_W'(1);
      end else begin
        scan_cnt_q <= '0;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    rsp_load    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt_q == SCAN_LAST) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        rsp_load = !rsp_valid_q || rsp_o.ready;
        if (rsp_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Scan addressing: read entry n while entry n-1 is processed
  assign id_ok     = (item_q.slot_id != '0) &&
                     (TIME_W'(item_q.slot_id) < TIME_W'(SLOT_COUNT));
  assign slot_idx  = IDX_W'(item_q.slot_id);
  assign cnt_m1    = scan_cnt_q - SCAN_W'(1);
  assign proc_idx  = cnt_m1[IDX_W-1:0];
  assign scan_proc = (state_q == ST_SCAN) && (scan_cnt_q != '0);

  assign ctl.first      = (state_q == ST_SCAN) && (scan_cnt_q == '0);
  assign ctl.sweep      = sweep_q;
  assign ctl.proc       = scan_proc;
  assign ctl.hb_hit     = scan_proc && id_ok && (item_q.req_type == REQ_HEARTBEAT) &&
                          (proc_idx == slot_idx);
  assign ctl.q_hit      = scan_proc && id_ok && (item_q.req_type == REQ_QUERY) &&
                          (proc_idx == slot_idx);
  assign ctl.sweep_slot = scan_proc && sweep_q && (proc_idx != '0);
  assign ctl.recovered  = item_q.recovered;
  assign ctl.load_count = item_q.load_count;
  assign ctl.seconds    = seconds_q;
  assign ctl.timeout    = heartbeat_timeout_q;

  nhm_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .idx_i   (proc_idx),
    .rdata_i (mem_rdata),
    .wdata_o (scan_wdata),
    .best_o  (best),
    .sts_o   (sts)
  );

  // Slot table: clearing pass or write-back of the scanned entry
  assign mem_we    = (state_q == ST_CLEAR) || scan_proc;
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : proc_idx;
  assign mem_wdata = (state_q == ST_CLEAR) ? nhm_entry_t'('0) : scan_wdata;
  assign mem_raddr = (scan_cnt_q < SCAN_LAST) ? scan_cnt_q[IDX_W-1:0] : '0;

  nhm_slot_ram #(
    .DEPTH (SLOT_COUNT),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Response register
  assign flush = (item_q.req_type == REQ_HEARTBEAT) && id_ok && item_q.recovered;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_q.slot_active       <= sts.q_active;
      rsp_q.slot_load         <= sts.q_load;
      rsp_q.flush_request     <= flush;
      rsp_q.flush_slot        <= flush ? item_q.slot_id : '0;
      rsp_q.least_loaded_slot <= ID_W'(best);
      rsp_q.active_slots      <= sts.alive_count;
      rsp_q.total_load        <= sts.load_sum;
      rsp_q.swept             <= sweep_q;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // Checks
  a_req_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> (state_q == ST_SCAN))
    else $error("accepted request did not start a table pass");

  a_finish_loads_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) && (!rsp_valid_q || rsp_o.ready) |=> rsp_valid_q)
    else $error("finished pass produced no response");

  a_we_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == ST_CLEAR) || (state_q == ST_SCAN)))
    else $error("slot table written outside clear or scan");

  a_flush_slot_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (!rsp_q.flush_request || (rsp_q.flush_slot != '0)))
    else $error("flush requested for slot zero");

endmodule

`default_nettype wire
